@@ rtl/core/skf_pkg.sv @@
`timescale 1ns / 1ps
package skf_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 24;
  localparam int EST_FRAC    = 16;
  localparam int EST_BITS    = SAMPLE_BITS + EST_FRAC;
  localparam int CNT_BITS    = $clog2(FRAC_BITS);
  localparam int IDX_BITS    = 8;
  localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [FRAC_BITS-1:0] Q_RESET = FRAC_BITS'(1678);
  localparam logic [FRAC_BITS-1:0] R_RESET = FRAC_BITS'(83886);

  localparam logic [IDX_BITS-1:0] CFG_PROCESS_NOISE     = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] CFG_MEASUREMENT_NOISE = IDX_BITS'(1);

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_corr;
    logic mul_var;
    logic commit;
  } skf_cmd_t;

endpackage

@@ rtl/core/scalar_kalman_smoother_unit.sv @@
`timescale 1ns / 1ps
// One-dimensional Kalman smoother for a stream of unsigned ADC samples.
// Input channel: one sample per beat on in_tdata, accepted when in_tvalid
// and in_tready are both high. Result channel: one filtered value per beat
// on out_tdata, the new estimate truncated to an integer.
// Configuration: cfg_index 0 writes the process noise, index 1 the
// measurement noise, both unsigned Q0.24; other indexes are ignored.
// cfg_ready is always high; write only while no sample is in flight.
// Each sample passes through the load, the bit-serial divider that forms
// the gain, the correction multiply, the variance multiply and the commit,
// in that order; the result is registered at the commit, and no new
// sample is taken until the commit of the last one is done.
// The result sits in an output register; while it waits the next sample
// is accepted and processed, and only its commit waits for the register
// to be emptied. Reset clears the estimate and variance to zero and
// loads the default noise values; no result is pending after reset.
module scalar_kalman_smoother_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [skf_pkg::TDATA_BITS-1:0]      in_tdata,   // [11:0] sample
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [skf_pkg::TDATA_BITS-1:0]      out_tdata,  // [11:0] filtered
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [skf_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [skf_pkg::FRAC_BITS-1:0]       cfg_data
);

  skf_pkg::skf_cmd_t               cmd;
  logic [skf_pkg::SAMPLE_BITS-1:0] filtered;

  assign cfg_ready = 1'b1;
  assign out_tdata = skf_pkg::TDATA_BITS'(filtered);

  skf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  skf_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sample    (in_tdata[skf_pkg::SAMPLE_BITS-1:0]),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .filtered  (filtered)
  );

endmodule

@@ rtl/core/skf_ctrl.sv @@
`timescale 1ns / 1ps
module skf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output skf_pkg::skf_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MULC = 3'd2;
  localparam logic [2:0] S_MULV = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [skf_pkg::CNT_BITS-1:0] CNT_LAST =
    skf_pkg::CNT_BITS'(skf_pkg::FRAC_BITS - 1);

  logic [2:0]                   state_r, state_nxt;
  logic [skf_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                         oval_r, oval_nxt;
  logic                         slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = oval_r;
  assign slot_free  = !oval_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    oval_nxt  = oval_r && !out_tready;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_MULC;
        end
      end
      S_MULC: begin
        cmd.mul_corr = 1'b1;
        state_nxt    = S_MULV;
      end
      S_MULV: begin
        cmd.mul_var = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          oval_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

@@ rtl/core/skf_dpath.sv @@
`timescale 1ns / 1ps
module skf_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  skf_pkg::skf_cmd_t               cmd,
  input  logic [skf_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                            cfg_we,
  input  logic [skf_pkg::IDX_BITS-1:0]    cfg_index,
  input  logic [skf_pkg::FRAC_BITS-1:0]   cfg_data,
  output logic [skf_pkg::SAMPLE_BITS-1:0] filtered
);

  localparam int F = skf_pkg::FRAC_BITS;
  localparam int E = skf_pkg::EST_BITS;

  logic [F-1:0]   q_r, r_r;
  logic [E-1:0]   est_r, target_r, corr_r;
  logic [F-1:0]   var_r, pred_r, gain_r, varn_r;
  logic [F:0]     denom_r, rem_r;
  logic [F-1:0]   quot_r;
  logic           up_r;
  logic [skf_pkg::SAMPLE_BITS-1:0] filt_r;

  logic [F:0]     pred_sum;
  logic [F-1:0]   pred_sat;
  logic [F:0]     denom_sum;
  logic [F+1:0]   rem_sh;
  logic           rem_ge;
  logic [F-1:0]   gain_sel;
  logic           est_up;
  logic [E-1:0]   diff;
  logic [F+E-1:0] corr_prod;
  logic [F:0]     one_minus;
  logic [2*F:0]   var_prod;
  logic [E-1:0]   est_new;

  assign pred_sum  = {1'b0, var_r} + {1'b0, q_r};
  assign pred_sat  = pred_sum[F] ? {F{1'b1}} : pred_sum[F-1:0];
  assign denom_sum = {1'b0, pred_sat} + {1'b0, r_r};

  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, denom_r};

  always_comb begin
    if (denom_r == '0) begin
      gain_sel = '0;
    end else if ({1'b0, pred_r} == denom_r) begin
      gain_sel = {F{1'b1}};
    end else begin
      gain_sel = quot_r;
    end
  end

  assign est_up    = target_r >= est_r;
  assign diff      = est_up ? (target_r - est_r) : (est_r - target_r);
  assign corr_prod = gain_sel * diff;

  assign one_minus = {1'b1, {F{1'b0}}} - {1'b0, gain_r};
  assign var_prod  = one_minus * pred_r;

  assign est_new = up_r ? (est_r + corr_r) : (est_r - corr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r   <= skf_pkg::Q_RESET;
      r_r   <= skf_pkg::R_RESET;
      est_r <= '0;
      var_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          skf_pkg::CFG_PROCESS_NOISE:     q_r <= cfg_data;
          skf_pkg::CFG_MEASUREMENT_NOISE: r_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        est_r <= est_new;
        var_r <= varn_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target_r <= {sample, {skf_pkg::EST_FRAC{1'b0}}};
      pred_r   <= pred_sat;
      denom_r  <= denom_sum;
      rem_r    <= {1'b0, pred_sat};
      quot_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= rem_ge ? (F+1)'(rem_sh - {1'b0, denom_r}) : rem_sh[F:0];
      quot_r <= {quot_r[F-2:0], rem_ge};
    end
    if (cmd.mul_corr) begin
      gain_r <= gain_sel;
      corr_r <= corr_prod[F+E-1:F];
      up_r   <= est_up;
    end
    if (cmd.mul_var) begin
      varn_r <= var_prod[2*F-1:F];
    end
    if (cmd.commit) begin
      filt_r <= est_new[E-1:skf_pkg::EST_FRAC];
    end
  end

  assign filtered = filt_r;

endmodule

@@ rtl/core/skf_checker.sv @@
`timescale 1ns / 1ps
module skf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [skf_pkg::TDATA_BITS-1:0] out_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready
);

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat pending straight after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second sample taken while one is in flight");

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[skf_pkg::TDATA_BITS-1:skf_pkg::SAMPLE_BITS] == '0)
    else $error("padding bits of the result are not zero");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed or vanished");

endmodule

bind scalar_kalman_smoother_unit skf_checker u_skf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

@@ sim/tb_scalar_kalman_smoother_unit.sv @@
`timescale 1ns / 1ps
module tb_scalar_kalman_smoother_unit;

  typedef logic [skf_pkg::SAMPLE_BITS-1:0] sample_t;
  typedef logic [skf_pkg::FRAC_BITS-1:0]   frac_t;
  typedef logic [skf_pkg::IDX_BITS-1:0]    reg_idx_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    reg_idx_t  idx;
    frac_t     data;
    sample_t   sample;
    logic      typed;
    sample_t   want;
  } dir_row_t;

  localparam reg_idx_t CFG_Q           = skf_pkg::CFG_PROCESS_NOISE;
  localparam reg_idx_t CFG_R           = skf_pkg::CFG_MEASUREMENT_NOISE;
  localparam reg_idx_t CFG_SPARE_FIRST = skf_pkg::IDX_BITS'(2);
  localparam reg_idx_t CFG_SPARE_LAST  = '1;
  localparam frac_t    NOISE_MAX       = '1;
  localparam frac_t    NOISE_MIN       = skf_pkg::FRAC_BITS'(1);
  localparam logic [63:0] FRAC_ONE     = 64'd1 << skf_pkg::FRAC_BITS;
  localparam logic [63:0] FRAC_MAX     = FRAC_ONE - 64'd1;
  localparam int       SAMPLE_MAX      = (1 << skf_pkg::SAMPLE_BITS) - 1;
  localparam int       PHASES          = 8;
  localparam int       PHASE_ITEMS     = 145;

  // A zero divisor leaves the gain at zero, so the estimate holds at zero.
  localparam dir_row_t DIR_ROWS [29] = '{
    '{ROW_WRITE,  CFG_Q,           '0,               '0,      1'b0, '0},
    '{ROW_WRITE,  CFG_R,           '0,               '0,      1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'hFFF, 1'b1, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'h000, 1'b1, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'h800, 1'b1, '0},
    '{ROW_WRITE,  CFG_Q,           NOISE_MAX,        '0,      1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'hFFF, 1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'h000, 1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'hFFF, 1'b0, '0},
    '{ROW_WRITE,  CFG_R,           NOISE_MAX,        '0,      1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'hFFF, 1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'hFFF, 1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'h000, 1'b0, '0},
    '{ROW_WRITE,  CFG_Q,           '0,               '0,      1'b0, '0},
    '{ROW_WRITE,  CFG_R,           NOISE_MIN,        '0,      1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'h4D2, 1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'h000, 1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'hFFF, 1'b0, '0},
    '{ROW_WRITE,  CFG_SPARE_FIRST, NOISE_MAX,        '0,      1'b0, '0},
    '{ROW_WRITE,  CFG_SPARE_LAST,  '0,               '0,      1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'h064, 1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'hBB8, 1'b0, '0},
    '{ROW_WRITE,  CFG_Q,           skf_pkg::Q_RESET, '0,      1'b0, '0},
    '{ROW_WRITE,  CFG_R,           skf_pkg::R_RESET, '0,      1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'h000, 1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'hFFF, 1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'h800, 1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'h7FF, 1'b0, '0},
    '{ROW_SAMPLE, CFG_Q,           '0,               12'h001, 1'b0, '0}
  };

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [skf_pkg::TDATA_BITS-1:0] in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [skf_pkg::TDATA_BITS-1:0] out_tdata;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  reg_idx_t                       cfg_index  = '0;
  frac_t                          cfg_data   = '0;

  frac_t                          q_reg;
  frac_t                          r_reg;
  logic [skf_pkg::EST_BITS-1:0]   est_fix;
  frac_t                          var_fix;
  sample_t                        filtered_q [$];
  int                             mismatches = 0;
  bit                             calm       = 1'b0;
  int                             burst_left = 0;
  int                             burst_mode = 0;
  int                             level      = 0;
  int                             spread     = 1;

  scalar_kalman_smoother_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (filtered_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result beat, filtered %0d", $realtime,
                   out_tdata[skf_pkg::SAMPLE_BITS-1:0]);
        end
      end else begin
        if (out_tdata[skf_pkg::SAMPLE_BITS-1:0] !== filtered_q[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: filtered expected %0d, got %0d", $realtime,
                     filtered_q[0], out_tdata[skf_pkg::SAMPLE_BITS-1:0]);
          end
        end
        void'(filtered_q.pop_front());
      end
    end
  end

  task automatic kalman_step(input sample_t s, output sample_t f);
    logic [63:0] target;
    logic [63:0] pred;
    logic [63:0] denom;
    logic [63:0] gain;
    logic [63:0] diff;
    logic [63:0] corr;
    target = 64'(s) << skf_pkg::EST_FRAC;
    pred   = 64'(var_fix) + 64'(q_reg);
    if (pred > FRAC_MAX) pred = FRAC_MAX;
    denom = pred + 64'(r_reg);
    if (denom == 64'd0) begin
      gain = 64'd0;
    end else begin
      gain = (pred << skf_pkg::FRAC_BITS) / denom;
      if (gain > FRAC_MAX) gain = FRAC_MAX;
    end
    if (target >= 64'(est_fix)) begin
      diff    = target - 64'(est_fix);
      corr    = (gain * diff) >> skf_pkg::FRAC_BITS;
      est_fix = est_fix + skf_pkg::EST_BITS'(corr);
    end else begin
      diff    = 64'(est_fix) - target;
      corr    = (gain * diff) >> skf_pkg::FRAC_BITS;
      est_fix = est_fix - skf_pkg::EST_BITS'(corr);
    end
    var_fix = skf_pkg::FRAC_BITS'(((FRAC_ONE - gain) * pred) >> skf_pkg::FRAC_BITS);
    f = est_fix[skf_pkg::EST_BITS-1 -: skf_pkg::SAMPLE_BITS];
  endtask

  task automatic send_sample(input sample_t s, input logic typed, input sample_t want);
    int      gap;
    sample_t f;
    if (!calm && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 60);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= skf_pkg::TDATA_BITS'(s);
    do @(posedge clk); while (!in_tready);
    kalman_step(s, f);
    filtered_q.push_back(typed ? want : f);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input frac_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_Q) begin
      q_reg = val;
    end else if (idx == CFG_R) begin
      r_reg = val;
    end
  endtask

  task automatic set_noise(input frac_t q, input frac_t r);
    drain();
    write_reg(CFG_Q, q);
    write_reg(CFG_R, r);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(reg_idx_t'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                frac_t'($urandom()));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic frac_t pick_noise(input logic measurement);
    case ($urandom_range(0, 5))
      0: return measurement ? NOISE_MIN : frac_t'(0);
      1: return NOISE_MAX;
      2: return frac_t'($urandom_range(0, 255));
      3: return frac_t'($urandom_range(0, 65535));
      default: return frac_t'($urandom());
    endcase
  endfunction

  // Mostly a noisy level held for a burst, so the variance gets time to settle.
  task automatic next_sample(output sample_t s);
    int v;
    if (burst_left == 0) begin
      burst_left = $urandom_range(5, 40);
      burst_mode = $urandom_range(0, 9);
      level      = $urandom_range(0, SAMPLE_MAX);
      spread     = 1 << $urandom_range(0, 7);
    end
    burst_left--;
    if (burst_mode < 6) begin
      v = level + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    end else if (burst_mode < 8) begin
      v = $urandom_range(0, SAMPLE_MAX);
    end else begin
      v = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : 0;
    end
    s = sample_t'(v);
  endtask

  initial begin
    sample_t s;
    int      sent;
    sent    = 0;
    q_reg   = skf_pkg::Q_RESET;
    r_reg   = skf_pkg::R_RESET;
    est_fix = '0;
    var_fix = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_WRITE) begin
        if (!cfg_valid) drain();
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
      end else begin
        cfg_valid <= 1'b0;
        send_sample(DIR_ROWS[i].sample, DIR_ROWS[i].typed, DIR_ROWS[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_noise(skf_pkg::Q_RESET, skf_pkg::R_RESET);
        1: set_noise('0, NOISE_MAX);
        2: set_noise(NOISE_MAX, NOISE_MIN);
        3: set_noise('0, '0);
        default: set_noise(pick_noise(1'b0), pick_noise(1'b1));
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        calm = (sent >= 450 && sent < 700);
        next_sample(s);
        send_sample(s, 1'b0, '0);
        sent++;
      end
    end

    calm = 1'b0;
    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/skf_pkg.sv
rtl/core/skf_ctrl.sv
rtl/core/skf_dpath.sv
rtl/core/scalar_kalman_smoother_unit.sv
rtl/core/skf_checker.sv
sim/tb_scalar_kalman_smoother_unit.sv
